[rtl/gwdf_pkg.sv]
// shared types and constants for the gyro window deadband feedforward block
`timescale 1ns / 1ps
`default_nettype none

package gwdf_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WLEN_W     = 8;
  localparam int THR_W      = 15;
  localparam int GAIN_W     = 16;
  localparam int FIELD_W    = 16;
  localparam int ELAPSED_W  = 8;
  localparam int TIME_W     = 9;
  localparam int RATE_W     = 16;
  localparam int PROD_W     = 32;
  localparam int COEF_W     = 17;
  localparam int CMD_W      = 34;
  localparam int COEF_SHIFT = 15;

  localparam logic [TIME_W-1:0] TIME_MAX = 9'd511;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAB_FACTOR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_GAIN    = 2'd3;

  localparam logic [WLEN_W-1:0]        RST_WINDOW_LENGTH = 8'd20;
  localparam logic [THR_W-1:0]         RST_DEADBAND      = 15'd8;
  localparam logic signed [GAIN_W-1:0] RST_STAB_FACTOR   = 16'sd4096;
  localparam logic signed [GAIN_W-1:0] RST_STICK_GAIN    = 16'sd0;

  typedef struct packed {
    logic [THR_W-1:0]         deadband_threshold;
    logic signed [GAIN_W-1:0] stabilization_factor;
    logic signed [GAIN_W-1:0] stick_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_DBAND,
    B_MUL,
    B_COEF,
    B_CMD
  } back_state_t;

endpackage

`default_nettype wire

[rtl/gwdf_front.sv]
// front end: takes items, accumulates the window and decides when it closes
`timescale 1ns / 1ps
`default_nettype none

module gwdf_front #(
  parameter int MAX_SAMPLES = 256,
  parameter int EFF_SW      = 16,
  parameter int SUM_W       = 24,
  parameter int CNT_W       = 9,
  parameter int ENTRY_W     = 50
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [gwdf_pkg::FIELD_W-1:0]  gyro_z,
  input  wire logic [gwdf_pkg::ELAPSED_W-1:0]       elapsed_ms,
  input  wire logic signed [gwdf_pkg::FIELD_W-1:0]  stick_x,
  input  wire logic [gwdf_pkg::WLEN_W-1:0]          window_length_ms,
  input  wire logic                                 q_full,
  output logic                                      push,
  output logic [ENTRY_W-1:0]                        entry
);

  logic signed [SUM_W-1:0]          sample_sum, sample_sum_next;
  logic [CNT_W-1:0]                 sample_count, sample_count_next;
  logic [gwdf_pkg::TIME_W-1:0]      window_time, window_time_next;
  logic [gwdf_pkg::TIME_W:0]        time_add;
  logic signed [EFF_SW-1:0]         sample;
  logic                             closed;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    sample            = gyro_z[EFF_SW-1:0];
    sample_sum_next   = sample_sum + SUM_W'(sample);
    sample_count_next = sample_count + CNT_W'(1);
    time_add          = (gwdf_pkg::TIME_W+1)'(window_time)
                      + (gwdf_pkg::TIME_W+1)'(elapsed_ms);
    window_time_next  = (time_add > (gwdf_pkg::TIME_W+1)'(gwdf_pkg::TIME_MAX))
                      ? gwdf_pkg::TIME_MAX : time_add[gwdf_pkg::TIME_W-1:0];
    closed = (window_time_next >= gwdf_pkg::TIME_W'(window_length_ms))
          || (sample_count_next >= CNT_W'(MAX_SAMPLES));
  end

  assign entry = {sample_sum_next, sample_count_next, closed, stick_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
      window_time  <= '0;
    end else if (push) begin
      if (closed) begin
        sample_sum   <= '0;
        sample_count <= '0;
        window_time  <= '0;
      end else begin
        sample_sum   <= sample_sum_next;
        sample_count <= sample_count_next;
        window_time  <= window_time_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/gwdf_queue.sv]
// short fifo between the front end and the back end
`timescale 1ns / 1ps
`default_nettype none

module gwdf_queue #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  full,
  output logic                  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OCC_W-1:0] occ;

  assign full      = (occ == OCC_W'(DEPTH));
  assign not_empty = (occ != '0);
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        occ <= occ + OCC_W'(1);
      end else if (pop && !push) begin
        occ <= occ - OCC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/gwdf_back.sv]
// back end: window mean divider, deadband, feedforward multiply and output register
`timescale 1ns / 1ps
`default_nettype none

module gwdf_back #(
  parameter int EFF_SW  = 16,
  parameter int SUM_W   = 24,
  parameter int CNT_W   = 9,
  parameter int ENTRY_W = 50
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire gwdf_pkg::cfg_t                       cfg,
  input  wire logic                                 q_not_empty,
  input  wire logic [ENTRY_W-1:0]                   q_data,
  output logic                                      pop,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [gwdf_pkg::CMD_W-1:0]         yaw_rate_command,
  output logic signed [gwdf_pkg::RATE_W-1:0]        held_rate,
  output logic                                      window_closed
);

  localparam int STEP_W = $clog2(SUM_W);
  localparam int CMP_W  = (SUM_W > gwdf_pkg::THR_W) ? SUM_W : gwdf_pkg::THR_W;

  gwdf_pkg::back_state_t state, state_next;

  logic signed [SUM_W-1:0]            e_sum;
  logic [CNT_W-1:0]                   e_count;
  logic                               e_closed;
  logic signed [gwdf_pkg::FIELD_W-1:0] e_stick;

  logic                               neg;
  logic [SUM_W-1:0]                   quo;
  logic [CNT_W-1:0]                   rem;
  logic [CNT_W-1:0]                   divisor;
  logic [STEP_W-1:0]                  step;
  logic                               closed;
  logic signed [gwdf_pkg::FIELD_W-1:0] stick;
  logic signed [gwdf_pkg::PROD_W-1:0] prod;
  logic signed [gwdf_pkg::COEF_W-1:0] coef;
  logic signed [gwdf_pkg::RATE_W-1:0] chassis_rate;

  logic [CNT_W:0]                     rem_sh;
  logic                               ge;
  logic [SUM_W-1:0]                   mean_full;
  logic signed [EFF_SW-1:0]           mean_s;
  logic signed [gwdf_pkg::PROD_W-1:0] prod_next;
  logic signed [gwdf_pkg::COEF_W-1:0] coef_next;
  logic signed [gwdf_pkg::CMD_W-2:0]  cmd_p;
  logic                               load_out;

  assign {e_sum, e_count, e_closed, e_stick} = q_data;

  always_comb begin
    rem_sh    = {rem, quo[SUM_W-1]};
    ge        = (rem_sh >= {1'b0, divisor});
    mean_full = neg ? -quo : quo;
    mean_s    = mean_full[EFF_SW-1:0];
    prod_next = gwdf_pkg::PROD_W'(cfg.stick_gain) * gwdf_pkg::PROD_W'(stick);
    coef_next = gwdf_pkg::COEF_W'(cfg.stabilization_factor)
              - gwdf_pkg::COEF_W'(prod >>> gwdf_pkg::COEF_SHIFT);
    cmd_p     = (gwdf_pkg::CMD_W-1)'(coef) * (gwdf_pkg::CMD_W-1)'(chassis_rate);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gwdf_pkg::B_IDLE: begin
        if (q_not_empty) begin
          state_next = e_closed ? gwdf_pkg::B_DIV : gwdf_pkg::B_MUL;
        end
      end
      gwdf_pkg::B_DIV: begin
        if (step == '0) begin
          state_next = gwdf_pkg::B_DBAND;
        end
      end
      gwdf_pkg::B_DBAND: state_next = gwdf_pkg::B_MUL;
      gwdf_pkg::B_MUL:   state_next = gwdf_pkg::B_COEF;
      gwdf_pkg::B_COEF:  state_next = gwdf_pkg::B_CMD;
      gwdf_pkg::B_CMD: begin
        if (!out_valid || !out_stall) begin
          state_next = gwdf_pkg::B_IDLE;
        end
      end
      default: state_next = gwdf_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    unique case (state)
      gwdf_pkg::B_IDLE: pop      = q_not_empty;
      gwdf_pkg::B_CMD:  load_out = !out_valid || !out_stall;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gwdf_pkg::B_IDLE;
      chassis_rate <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == gwdf_pkg::B_DBAND) begin
        chassis_rate <= (CMP_W'(quo) > CMP_W'(cfg.deadband_threshold))
                      ? gwdf_pkg::RATE_W'(mean_s) : '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      neg     <= e_sum[SUM_W-1];
      quo     <= e_sum[SUM_W-1] ? -e_sum : e_sum;
      rem     <= '0;
      divisor <= e_count;
      step    <= STEP_W'(SUM_W - 1);
      closed  <= e_closed;
      stick   <= e_stick;
    end else if (state == gwdf_pkg::B_DIV) begin
      rem  <= ge ? CNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[CNT_W-1:0];
      quo  <= {quo[SUM_W-2:0], ge};
      step <= step - STEP_W'(1);
    end
    if (state == gwdf_pkg::B_MUL) begin
      prod <= prod_next;
    end
    if (state == gwdf_pkg::B_COEF) begin
      coef <= coef_next;
    end
    if (load_out) begin
      yaw_rate_command <= gwdf_pkg::CMD_W'(cmd_p);
      held_rate        <= chassis_rate;
      window_closed    <= closed;
    end
  end

endmodule

`default_nettype wire

[rtl/gyro_window_deadband_feedforward.sv]
// top level of the gyro window deadband feedforward block
// path: queue, then in the back end the bit-serial mean divider and deadband step (only
//   for an item that closes a window), then multiply, coefficient and command states
// throughput: the back end pops the next item only after the last leaves the command
//   state, which an output stall holds; a 2-entry queue decouples input
// reset: synchronous, restores register defaults and clears accumulators and held chassis rate
`timescale 1ns / 1ps
`default_nettype none

module gyro_window_deadband_feedforward #(
  parameter int MAX_SAMPLES_PER_WINDOW = 256,
  parameter int SAMPLE_BITS            = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_we,
  input  wire logic [gwdf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [gwdf_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [gwdf_pkg::FIELD_W-1:0]     gyro_z,
  input  wire logic [gwdf_pkg::ELAPSED_W-1:0]          elapsed_ms,
  input  wire logic signed [gwdf_pkg::FIELD_W-1:0]     stick_x,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [gwdf_pkg::CMD_W-1:0]            yaw_rate_command,
  output logic signed [gwdf_pkg::RATE_W-1:0]           held_rate,
  output logic                                         window_closed
);

  localparam int EFF_SW  = (SAMPLE_BITS < gwdf_pkg::FIELD_W) ? SAMPLE_BITS
                                                              : gwdf_pkg::FIELD_W;
  localparam int SUM_W   = EFF_SW + $clog2(MAX_SAMPLES_PER_WINDOW);
  localparam int CNT_W   = $clog2(MAX_SAMPLES_PER_WINDOW + 1);
  localparam int ENTRY_W = SUM_W + CNT_W + 1 + gwdf_pkg::FIELD_W;

  logic [gwdf_pkg::WLEN_W-1:0] window_length_ms;
  gwdf_pkg::cfg_t              cfg;
  logic                        push, pop, q_full, q_not_empty;
  logic [ENTRY_W-1:0]          wr_entry, rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length_ms         <= gwdf_pkg::RST_WINDOW_LENGTH;
      cfg.deadband_threshold   <= gwdf_pkg::RST_DEADBAND;
      cfg.stabilization_factor <= gwdf_pkg::RST_STAB_FACTOR;
      cfg.stick_gain           <= gwdf_pkg::RST_STICK_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gwdf_pkg::CFG_WINDOW_LENGTH: window_length_ms <= cfg_data[gwdf_pkg::WLEN_W-1:0];
        gwdf_pkg::CFG_DEADBAND:      cfg.deadband_threshold <= cfg_data[gwdf_pkg::THR_W-1:0];
        gwdf_pkg::CFG_STAB_FACTOR:   cfg.stabilization_factor <= cfg_data;
        gwdf_pkg::CFG_STICK_GAIN:    cfg.stick_gain <= cfg_data;
        default:                     window_length_ms <= window_length_ms;
      endcase
    end
  end

  gwdf_front #(
    .MAX_SAMPLES (MAX_SAMPLES_PER_WINDOW),
    .EFF_SW      (EFF_SW),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .gyro_z           (gyro_z),
    .elapsed_ms       (elapsed_ms),
    .stick_x          (stick_x),
    .window_length_ms (window_length_ms),
    .q_full           (q_full),
    .push             (push),
    .entry            (wr_entry)
  );

  gwdf_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (wr_entry),
    .pop       (pop),
    .rd_data   (rd_entry),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  gwdf_back #(
    .EFF_SW  (EFF_SW),
    .SUM_W   (SUM_W),
    .CNT_W   (CNT_W),
    .ENTRY_W (ENTRY_W)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_not_empty      (q_not_empty),
    .q_data           (rd_entry),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .yaw_rate_command (yaw_rate_command),
    .held_rate        (held_rate),
    .window_closed    (window_closed)
  );

endmodule

`default_nettype wire

[rtl/gwdf_checker.sv]
// port-level checks for the gyro window deadband feedforward block
`timescale 1ns / 1ps
`default_nettype none

module gwdf_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [gwdf_pkg::CMD_W-1:0]   yaw_rate_command,
  input wire logic signed [gwdf_pkg::RATE_W-1:0]  held_rate,
  input wire logic                                window_closed
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(yaw_rate_command) && $stable(held_rate)
                               && $stable(window_closed))
    else $error("output item changed while stalled");

  a_zero_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid && (held_rate == '0) |-> (yaw_rate_command == '0))
    else $error("nonzero command with zero held rate");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind gyro_window_deadband_feedforward gwdf_checker u_gwdf_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .yaw_rate_command (yaw_rate_command),
  .held_rate        (held_rate),
  .window_closed    (window_closed)
);

`default_nettype wire

[verif/gyro_window_deadband_feedforward_test.sv]
// self-checking testbench for the gyro window deadband feedforward block
`timescale 1ns / 1ps

module gyro_window_deadband_feedforward_test;

  localparam int MAX_SAMPLES  = 256;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 100;

  typedef struct packed {
    logic signed [gwdf_pkg::CMD_W-1:0]  cmd;
    logic signed [gwdf_pkg::RATE_W-1:0] rate;
    logic                               closed;
  } yaw_result_t;

  class yaw_ff_scoreboard;
    logic [gwdf_pkg::WLEN_W-1:0]        win_len;
    logic [gwdf_pkg::THR_W-1:0]         thr;
    logic signed [gwdf_pkg::GAIN_W-1:0] stab;
    logic signed [gwdf_pkg::GAIN_W-1:0] gain;
    logic signed [23:0]                 sum;
    logic [gwdf_pkg::TIME_W-1:0]        count;
    logic [gwdf_pkg::TIME_W-1:0]        win_time;
    logic signed [gwdf_pkg::RATE_W-1:0] rate;
    yaw_result_t                        expected_q[$];
    int                                 errors;

    function new();
      win_len  = gwdf_pkg::RST_WINDOW_LENGTH;
      thr      = gwdf_pkg::RST_DEADBAND;
      stab     = gwdf_pkg::RST_STAB_FACTOR;
      gain     = gwdf_pkg::RST_STICK_GAIN;
      sum      = '0;
      count    = '0;
      win_time = '0;
      rate     = '0;
      errors   = 0;
    endfunction

    function void set_reg(logic [gwdf_pkg::CFG_IDX_W-1:0] idx,
                          logic [gwdf_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        gwdf_pkg::CFG_WINDOW_LENGTH: win_len = data[gwdf_pkg::WLEN_W-1:0];
        gwdf_pkg::CFG_DEADBAND:      thr = data[gwdf_pkg::THR_W-1:0];
        gwdf_pkg::CFG_STAB_FACTOR:   stab = data;
        gwdf_pkg::CFG_STICK_GAIN:    gain = data;
        default: ;
      endcase
    endfunction

    function void note_item(logic signed [gwdf_pkg::FIELD_W-1:0] g,
                            logic [gwdf_pkg::ELAPSED_W-1:0] e,
                            logic signed [gwdf_pkg::FIELD_W-1:0] s);
      logic [gwdf_pkg::TIME_W:0]          t;
      int                                 mean;
      int                                 mag;
      logic signed [gwdf_pkg::PROD_W-1:0] stick_prod;
      logic signed [gwdf_pkg::COEF_W-1:0] coef;
      yaw_result_t                        r;
      sum   = sum + 24'(g);
      count = count + 1'b1;
      t     = (gwdf_pkg::TIME_W+1)'(win_time) + (gwdf_pkg::TIME_W+1)'(e);
      if (t > gwdf_pkg::TIME_MAX) t = gwdf_pkg::TIME_MAX;
      win_time = t[gwdf_pkg::TIME_W-1:0];
      r.closed = 1'b0;
      if (win_time >= win_len || count >= MAX_SAMPLES) begin
        mean = int'(sum) / int'(count);
        mag  = (mean < 0) ? -mean : mean;
        rate = (mag > int'(thr)) ? mean[gwdf_pkg::RATE_W-1:0] : '0;
        sum      = '0;
        count    = '0;
        win_time = '0;
        r.closed = 1'b1;
      end
      stick_prod = gwdf_pkg::PROD_W'(gain) * gwdf_pkg::PROD_W'(s);
      coef       = gwdf_pkg::COEF_W'(stab)
                 - gwdf_pkg::COEF_W'(stick_prod >>> gwdf_pkg::COEF_SHIFT);
      r.cmd      = gwdf_pkg::CMD_W'(coef) * gwdf_pkg::CMD_W'(rate);
      r.rate     = rate;
      expected_q.push_back(r);
    endfunction

    function void flag(string what, longint want, longint got);
      errors++;
      if (errors <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic signed [gwdf_pkg::CMD_W-1:0] cmd,
                               logic signed [gwdf_pkg::RATE_W-1:0] held,
                               logic closed);
      yaw_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: result with no item pending, expected none, actual cmd %0d rate %0d",
                   $time, cmd, held);
        return;
      end
      want = expected_q.pop_front();
      if (want.cmd !== cmd) flag("yaw_rate_command", want.cmd, cmd);
      if (want.rate !== held) flag("held_rate", want.rate, held);
      if (want.closed !== closed) flag("window_closed", want.closed, closed);
    endfunction
  endclass

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_we = 1'b0;
  logic [gwdf_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [gwdf_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [gwdf_pkg::FIELD_W-1:0]  gyro_z = '0;
  logic [gwdf_pkg::ELAPSED_W-1:0]       elapsed_ms = '0;
  logic signed [gwdf_pkg::FIELD_W-1:0]  stick_x = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic signed [gwdf_pkg::CMD_W-1:0]    yaw_rate_command;
  logic signed [gwdf_pkg::RATE_W-1:0]   held_rate;
  logic                                 window_closed;

  logic quiet = 1'b0;
  int   stall_left = 0;
  int   idle_cycles = 0;

  yaw_ff_scoreboard sb = new();

  gyro_window_deadband_feedforward dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .gyro_z           (gyro_z),
    .elapsed_ms       (elapsed_ms),
    .stick_x          (stick_x),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .yaw_rate_command (yaw_rate_command),
    .held_rate        (held_rate),
    .window_closed    (window_closed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(yaw_rate_command, held_rate, window_closed);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("gyro_window_deadband_feedforward_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [gwdf_pkg::FIELD_W-1:0] pick_field(
    input logic signed [gwdf_pkg::FIELD_W-1:0] center);
    case ($urandom_range(0, 9))
      0:       pick_field = ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
      1, 2:    pick_field = 16'($urandom);
      default: pick_field = center + 16'($urandom_range(0, 127)) - 16'd64;
    endcase
  endfunction

  function automatic logic [gwdf_pkg::CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       pick_gain = 16'h7FFF;
      1:       pick_gain = 16'h8000;
      2:       pick_gain = 16'h1000;
      3:       pick_gain = 16'h0000;
      default: pick_gain = 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic signed [gwdf_pkg::FIELD_W-1:0] g,
                           input logic [gwdf_pkg::ELAPSED_W-1:0] e,
                           input logic signed [gwdf_pkg::FIELD_W-1:0] s);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    gyro_z     <= g;
    elapsed_ms <= e;
    stick_x    <= s;
    do @(posedge clk); while (in_stall);
    sb.note_item(g, e, s);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gwdf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gwdf_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  initial begin
    logic [gwdf_pkg::CFG_DATA_W-1:0]     d;
    logic signed [gwdf_pkg::FIELD_W-1:0] gyro_base;
    logic signed [gwdf_pkg::FIELD_W-1:0] stick_base;
    logic [gwdf_pkg::ELAPSED_W-1:0]      e;
    int                                  emode;
    int                                  n;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default settings: deadband edges, extremes, truncation of a negative mean
    send_item(16'sd8, 8'd20, 16'sd0);
    send_item(-16'sd8, 8'd20, 16'sd0);
    send_item(16'sd9, 8'd20, 16'sd16384);
    send_item(-16'sd9, 8'd20, -16'sd1);
    send_item(16'sh7FFF, 8'd255, 16'sh7FFF);
    send_item(16'sh8000, 8'd255, 16'sh8000);
    send_item(-16'sd30, 8'd10, 16'sd0);
    send_item(-16'sd41, 8'd10, 16'sd0);
    send_item(16'sd100, 8'd0, 16'sd12345);
    send_item(-16'sd100, 8'd19, -16'sd12345);
    send_item(16'sd5, 8'd1, 16'sd0);

    // zero window length closes on every item
    settle();
    write_reg(gwdf_pkg::CFG_WINDOW_LENGTH, 16'hAB00);
    write_reg(gwdf_pkg::CFG_DEADBAND, 16'h8000);
    write_reg(gwdf_pkg::CFG_STAB_FACTOR, 16'h7FFF);
    write_reg(gwdf_pkg::CFG_STICK_GAIN, 16'h8000);
    cfg_we <= 1'b0;
    send_item(16'sh8000, 8'd0, 16'sh7FFF);
    send_item(16'sh7FFF, 8'd0, 16'sh8000);
    send_item(16'sd1, 8'd0, 16'sh8000);
    send_item(-16'sd1, 8'd0, 16'sd0);
    send_item(16'sd0, 8'd0, 16'sh7FFF);

    // largest threshold, shortest nonzero window
    settle();
    write_reg(gwdf_pkg::CFG_WINDOW_LENGTH, 16'h5501);
    write_reg(gwdf_pkg::CFG_DEADBAND, 16'hFFFF);
    write_reg(gwdf_pkg::CFG_STAB_FACTOR, 16'h8000);
    write_reg(gwdf_pkg::CFG_STICK_GAIN, 16'h7FFF);
    cfg_we <= 1'b0;
    send_item(16'sh7FFF, 8'd1, 16'sh8000);
    send_item(16'sh8000, 8'd0, 16'sh7FFF);
    send_item(16'sh8000, 8'd1, 16'sh8000);
    send_item(16'sh8000, 8'd255, 16'sh7FFF);

    for (int p = 0; p < 9; p++) begin
      settle();
      d = 16'($urandom);
      case ($urandom_range(0, 5))
        0:       d[gwdf_pkg::WLEN_W-1:0] = 8'd1;
        1:       d[gwdf_pkg::WLEN_W-1:0] = 8'd255;
        2:       d[gwdf_pkg::WLEN_W-1:0] = 8'd0;
        default: d[gwdf_pkg::WLEN_W-1:0] = 8'($urandom_range(1, 40));
      endcase
      // long window with no elapsed time fills the sample count
      if (p == 3) d[gwdf_pkg::WLEN_W-1:0] = 8'd255;
      write_reg(gwdf_pkg::CFG_WINDOW_LENGTH, d);
      d = 16'($urandom);
      case ($urandom_range(0, 4))
        0:       d[gwdf_pkg::THR_W-1:0] = '0;
        1:       d[gwdf_pkg::THR_W-1:0] = '1;
        default: d[gwdf_pkg::THR_W-1:0] = 15'($urandom_range(0, 200));
      endcase
      write_reg(gwdf_pkg::CFG_DEADBAND, d);
      write_reg(gwdf_pkg::CFG_STAB_FACTOR, pick_gain());
      write_reg(gwdf_pkg::CFG_STICK_GAIN, pick_gain());
      cfg_we <= 1'b0;
      if (p == 8) quiet <= 1'b1;
      gyro_base  = $signed(16'($urandom)) >>> $urandom_range(0, 12);
      stick_base = $signed(16'($urandom));
      emode      = $urandom_range(0, 2);
      n          = (p == 3) ? 300 : 155;
      for (int i = 0; i < n; i++) begin
        if (p == 3) begin
          e = 8'd0;
        end else begin
          case (emode)
            0:       e = 8'($urandom_range(0, 3));
            1:       e = 8'($urandom);
            default: e = 8'($urandom_range(0, 30));
          endcase
        end
        send_item(pick_field(gyro_base), e, pick_field(stick_base));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("gyro_window_deadband_feedforward_test: done, clean");
    end else begin
      $display("gyro_window_deadband_feedforward_test: done, errors");
    end
    $finish;
  end

endmodule
